FILE: rtl/spanning_tree_edge_filter_defines.svh
// Assertion macros for the spanning tree edge filter checker.
`ifndef SPANNING_TREE_EDGE_FILTER_DEFINES_SVH
`define SPANNING_TREE_EDGE_FILTER_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define STEF_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("stef assertion failed");

// Next-cycle implication, disabled while reset is high.
`define STEF_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("stef assertion failed");

`endif

FILE: rtl/stef_pkg.sv
// Shared types and constants for the spanning tree edge filter.
`default_nettype none
package stef_pkg;

  localparam int MAX_NODES    = 1024;
  localparam int ADDR_BITS    = $clog2(MAX_NODES);
  localparam int VERTEX_BITS  = 10;
  localparam int WEIGHT_BITS  = 16;
  localparam int COUNT_BITS   = 10;
  localparam int EPOCH_BITS   = 6;

  localparam logic [VERTEX_BITS-1:0] VERTEX_COUNT_RESET = VERTEX_BITS'(1023);

  // One parent table entry: the epoch it was written in and the parent link.
  typedef struct packed {
    logic [EPOCH_BITS-1:0] epoch;
    logic [ADDR_BITS-1:0]  parent;
  } entry_t;

  // Write port of the parent table.
  typedef struct packed {
    logic                 en;
    logic [ADDR_BITS-1:0] addr;
    entry_t               data;
  } mem_wr_t;

endpackage
`default_nettype wire

FILE: rtl/stef_parent_mem.sv
// Parent table memory: one write port and one registered read port.
`default_nettype none
module stef_parent_mem (
  input  wire logic                           clk,
  input  wire stef_pkg::mem_wr_t              wr,
  input  wire logic [stef_pkg::ADDR_BITS-1:0] rd_addr,
  output stef_pkg::entry_t                    rd_data
);

  stef_pkg::entry_t mem [stef_pkg::MAX_NODES];

  // Synchronous write.
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  // Registered read.
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule
`default_nettype wire

FILE: rtl/spanning_tree_edge_filter.sv
// Spanning tree edge filter: sorted edges in, accepted or rejected verdicts out.
//
// Kruskal edge selection over a union-find forest held in a 1024-entry parent
// table. Each edge takes one transaction on the s_ side and gives one on the
// m_ side. An accepted edge walks from each endpoint to its root and then
// links the two roots; an edge whose roots match skips the link.
// One compare unit walks both roots, with one table read and one compare per
// link, through the single read port of the parent table. Bad or surplus
// edges skip the walks. Entries carry an epoch tag so that a start of a new
// graph costs nothing. After reset, and on every 63rd start, a clearing pass
// sweeps all 1024 table entries while s_tready stays low. Results wait in an
// output register, so a stalled m_ side holds the block only once the next
// verdict is ready.
`default_nettype none
module spanning_tree_edge_filter (
  input  wire logic        clk,
  input  wire logic        rst,
  // Configuration: vertex_count.
  input  wire logic        cfg_wr_en,
  input  wire logic [9:0]  cfg_wr_data,
  // Edge input.
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [39:0] s_tdata,   // from_vertex[9:0], to_vertex[19:10], edge_weight[35:20]
  input  wire logic        s_tuser,   // start_graph
  // Verdict output.
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [47:0]      m_tdata,   // out_edge_from[9:0], out_edge_to[19:10],
                                      // out_weight[35:20], tree_edges[45:36]
  output logic [2:0]       m_tuser    // accepted[0], complete[1], bad_vertex[2]
);

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_CHECK, ST_RD_A, ST_CMP_A, ST_RD_B, ST_CMP_B, ST_LINK, ST_EMIT
  } state_t;

  localparam logic [stef_pkg::ADDR_BITS-1:0] LAST_ADDR =
    stef_pkg::ADDR_BITS'(stef_pkg::MAX_NODES - 1);
  localparam logic [stef_pkg::EPOCH_BITS-1:0] EPOCH_LAST = '1;
  localparam logic [stef_pkg::EPOCH_BITS-1:0] EPOCH_FIRST = stef_pkg::EPOCH_BITS'(1);

  state_t                              state;
  logic [stef_pkg::EPOCH_BITS-1:0]     epoch;
  logic [stef_pkg::ADDR_BITS-1:0]      clr_addr;
  logic                                item_pending;
  logic [stef_pkg::VERTEX_BITS-1:0]    vertex_count;
  logic [stef_pkg::COUNT_BITS-1:0]     count;
  logic [stef_pkg::VERTEX_BITS-1:0]    item_from;
  logic [stef_pkg::VERTEX_BITS-1:0]    item_to;
  logic [stef_pkg::WEIGHT_BITS-1:0]    item_weight;
  logic [stef_pkg::ADDR_BITS-1:0]      cur;
  logic [stef_pkg::ADDR_BITS-1:0]      root_a;
  logic                                acc;
  logic                                bad;

  stef_pkg::mem_wr_t                   mem_wr;
  stef_pkg::entry_t                    rd_data;
  logic [stef_pkg::ADDR_BITS-1:0]      link;
  logic [stef_pkg::COUNT_BITS-1:0]     needed;
  logic                                bad_item;
  logic                                out_free;

  stef_parent_mem u_mem (
    .clk     (clk),
    .wr      (mem_wr),
    .rd_addr (cur),
    .rd_data (rd_data)
  );

  // Parent link of the node just read; stale epochs read as a singleton.
  assign link = (rd_data.epoch == epoch) ? rd_data.parent : cur;

  // Edges needed for a full tree, saturating at zero.
  assign needed = (vertex_count != '0) ?
                  stef_pkg::COUNT_BITS'(vertex_count - 1'b1) : '0;

  // Endpoint range check.
  assign bad_item = (item_from == '0) || (item_from > vertex_count) ||
                    (item_to == '0) || (item_to > vertex_count);

  assign out_free = !m_tvalid || m_tready;
  assign s_tready = (state == ST_IDLE);

  // Parent table writes: the clearing sweep or the link of two roots.
  always_comb begin
    mem_wr = '0;
    if (state == ST_CLEAR) begin
      mem_wr.en          = 1'b1;
      mem_wr.addr        = clr_addr;
      mem_wr.data.epoch  = '0;
      mem_wr.data.parent = clr_addr;
    end else if (state == ST_LINK) begin
      mem_wr.en          = 1'b1;
      mem_wr.addr        = root_a;
      mem_wr.data.epoch  = epoch;
      mem_wr.data.parent = cur;
    end
  end

  // Sequencer, registers and output stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_CLEAR;
      epoch        <= EPOCH_FIRST;
      clr_addr     <= '0;
      item_pending <= 1'b0;
      vertex_count <= stef_pkg::VERTEX_COUNT_RESET;
      count        <= '0;
      acc          <= 1'b0;
      bad          <= 1'b0;
      m_tvalid     <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        vertex_count <= cfg_wr_data;
      end
      // A verdict leaves the output register unless the next one replaces it.
      if (m_tvalid && m_tready && (state != ST_EMIT)) begin
        m_tvalid <= 1'b0;
      end

      case (state)
        ST_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == LAST_ADDR) begin
            epoch        <= EPOCH_FIRST;
            item_pending <= 1'b0;
            state        <= item_pending ? ST_CHECK : ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (s_tvalid) begin
            item_from   <= s_tdata[9:0];
            item_to     <= s_tdata[19:10];
            item_weight <= s_tdata[35:20];
            acc         <= 1'b0;
            bad         <= 1'b0;
            if (s_tuser) begin
              count <= '0;
              if (epoch == EPOCH_LAST) begin
                item_pending <= 1'b1;
                state        <= ST_CLEAR;
              end else begin
                epoch <= epoch + 1'b1;
                state <= ST_CHECK;
              end
            end else begin
              state <= ST_CHECK;
            end
          end
        end
        ST_CHECK: begin
          if (bad_item) begin
            bad   <= 1'b1;
            state <= ST_EMIT;
          end else if (count < needed) begin
            cur   <= stef_pkg::ADDR_BITS'(item_from);
            state <= ST_RD_A;
          end else begin
            state <= ST_EMIT;
          end
        end
        ST_RD_A: begin
          state <= ST_CMP_A;
        end
        ST_CMP_A: begin
          if (link == cur) begin
            root_a <= cur;
            cur    <= stef_pkg::ADDR_BITS'(item_to);
            state  <= ST_RD_B;
          end else begin
            cur   <= link;
            state <= ST_RD_A;
          end
        end
        ST_RD_B: begin
          state <= ST_CMP_B;
        end
        ST_CMP_B: begin
          if (link == cur) begin
            state <= (root_a != cur) ? ST_LINK : ST_EMIT;
          end else begin
            cur   <= link;
            state <= ST_RD_B;
          end
        end
        ST_LINK: begin
          count <= count + 1'b1;
          acc   <= 1'b1;
          state <= ST_EMIT;
        end
        ST_EMIT: begin
          if (out_free) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {2'b00, count, item_weight, item_to, item_from};
            m_tuser  <= {bad, (count >= needed), acc};
            state    <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

FILE: rtl/stef_checker.sv
// Port-level checker for the spanning tree edge filter, bound to the top level.
`default_nettype none
`include "spanning_tree_edge_filter_defines.svh"
module stef_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        cfg_wr_en,
  input wire logic [9:0]  cfg_wr_data,
  input wire logic        s_tvalid,
  input wire logic        s_tready,
  input wire logic [39:0] s_tdata,
  input wire logic        s_tuser,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [47:0] m_tdata,
  input wire logic [2:0]  m_tuser
);

  // A stalled result holds its contents.
  `STEF_ASSERT_NEXT(a_out_hold, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser))

  // One edge at a time: the input closes right after a transaction.
  `STEF_ASSERT_NEXT(a_one_at_a_time, clk, rst, s_tvalid && s_tready, !s_tready)

  // An edge with a bad endpoint is never accepted.
  `STEF_ASSERT_IMPL(a_bad_not_accepted, clk, rst, m_tvalid, !(m_tuser[0] && m_tuser[2]))

  // An accepted edge leaves a nonzero tree edge count.
  `STEF_ASSERT_IMPL(a_accept_counts, clk, rst, m_tvalid && m_tuser[0], m_tdata[45:36] != 10'd0)

endmodule

bind spanning_tree_edge_filter stef_checker u_stef_checker (.*);
`default_nettype wire
